### rtl/core/ats_pkg.sv
package ats_pkg;

	localparam int KIND_BITS   = 5;
	localparam int LINE_FIELD  = 20;
	localparam int POS_FIELD   = 24;
	localparam int PREFIX_BITS = 40;
	localparam int MNEMONICS   = 16;

	localparam logic [KIND_BITS-1:0] KIND_INT            = 5'd0;
	localparam logic [KIND_BITS-1:0] KIND_LABEL          = 5'd1;
	localparam logic [KIND_BITS-1:0] KIND_IDENT          = 5'd2;
	localparam logic [KIND_BITS-1:0] KIND_ERROR          = 5'd3;
	localparam logic [KIND_BITS-1:0] KIND_END            = 5'd4;
	localparam logic [KIND_BITS-1:0] KIND_FIRST_MNEMONIC = 5'd5;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	// Mnemonic text packed with the first character in the highest used byte,
	// in token kind order starting at KIND_FIRST_MNEMONIC.
	localparam logic [PREFIX_BITS-1:0] MNEMONIC_TEXT [MNEMONICS] = '{
		40'h0050555348, // PUSH
		40'h0000504F50, // POP
		40'h0000445550, // DUP
		40'h0053574150, // SWAP
		40'h004F564552, // OVER
		40'h00004E4950, // NIP
		40'h005455434B, // TUCK
		40'h005049434B, // PICK
		40'h0000414444, // ADD
		40'h0000535542, // SUB
		40'h00004D554C, // MUL
		40'h0000444956, // DIV
		40'h0049464551, // IFEQ
		40'h00004A4D50, // JMP
		40'h0048414C54, // HALT
		40'h5052494E54  // PRINT
	};

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [LINE_FIELD-1:0] line;
		logic [POS_FIELD-1:0]  start;
		logic [POS_FIELD-1:0]  length;
		logic                  last;
	} token_t;

	typedef struct packed {
		logic first;
		logic second;
	} push_t;

endpackage

### rtl/core/assembly_token_scanner_core.sv
// Channel  | Dir | tdata                                  | tuser      | tlast
// s_axis   | in  | char_code[7:0]                         | -          | -
// m_axis   | out | line[19:0] start[43:20] length[67:44]  | kind[4:0]  | last_of_run
//
// One source byte is taken per cycle unless stalled; its beats are offered from the queue.
// A byte sits in a one-deep input register; the scan logic and state update run from it
// and push up to two result beats into a four-entry output queue.
// The input stalls only while fewer than two queue entries are free, since a byte that
// flushes a pending token and makes one of its own pushes two beats.
// Reset clears the scan state to line 1, offset 0, with nothing pending.
module assembly_token_scanner_core #(
	parameter int POSITION_BITS = 24,
	parameter int LINE_BITS     = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [19:0] line_number, [43:20] start_offset,
	                              // [67:44] token_length, [71:68] zero
	output logic [4:0]  m_tuser,  // [4:0] token_kind
	output logic        m_tlast   // last_of_run
);

	ats_pkg::push_t  push;
	ats_pkg::token_t res0, res1, out_token;
	logic            room;

	ats_scan #(
		.POSITION_BITS(POSITION_BITS),
		.LINE_BITS    (LINE_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_byte (s_tdata),
		.in_ready(s_tready),
		.room    (room),
		.push    (push),
		.res0    (res0),
		.res1    (res1)
	);

	ats_out_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr0      (res0),
		.wr1      (res1),
		.room     (room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_token(out_token)
	);

	assign m_tdata = {4'b0000, out_token.length, out_token.start, out_token.line};
	assign m_tuser = out_token.kind;
	assign m_tlast = out_token.last;

endmodule

### rtl/core/ats_scan.sv
module ats_scan #(
	parameter int POSITION_BITS = 24,
	parameter int LINE_BITS     = 20
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     in_byte,
	output logic           in_ready,
	input  logic           room,
	output ats_pkg::push_t push,
	output ats_pkg::token_t res0,
	output ats_pkg::token_t res1
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_COMMENT,
		MODE_MINUS,
		MODE_NUMBER,
		MODE_WORD
	} mode_t;

	localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
	localparam logic [LINE_BITS-1:0]     LINE_MAX = '1;

	mode_t                            mode_q, mode_n;
	logic [POSITION_BITS-1:0]         pos_q, pos_n, begin_q, begin_n, pos_inc;
	logic [LINE_BITS-1:0]             line_q, line_n;
	logic [ats_pkg::PREFIX_BITS-1:0]  prefix_q, prefix_n;
	logic                             too_long_q, too_long_n;
	logic [7:0]                       byte_s1;
	logic                             valid_s1;
	logic                             fire;

	logic                             is_digit, is_alpha, is_word;
	logic                             go_on;
	logic                             emit_a, emit_b, last_b_only;
	ats_pkg::token_t                  tok_a, tok_b;
	logic [ats_pkg::KIND_BITS-1:0]    word_kind;
	logic                             len_label;
	logic [POSITION_BITS:0]           len_end, len_diff;
	logic [POSITION_BITS-1:0]         len_sat;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	assign is_digit = (byte_s1 >= ats_pkg::CH_ZERO) && (byte_s1 <= ats_pkg::CH_NINE);
	assign is_alpha = ((byte_s1 >= ats_pkg::CH_UP_A) && (byte_s1 <= ats_pkg::CH_UP_Z)) ||
	                  ((byte_s1 >= ats_pkg::CH_LO_A) && (byte_s1 <= ats_pkg::CH_LO_Z));
	assign is_word  = is_alpha || is_digit || (byte_s1 == ats_pkg::CH_UNDER);
	assign pos_inc  = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;

	always_comb begin
		word_kind = ats_pkg::KIND_IDENT;
		if (!too_long_q) begin
			for (int i = ats_pkg::MNEMONICS - 1; i >= 0; i--) begin
				if (prefix_q == ats_pkg::MNEMONIC_TEXT[i])
					word_kind = ats_pkg::KIND_FIRST_MNEMONIC + 5'(i);
			end
		end
	end

	// A label's length runs through its colon, one past the current position.
	assign len_label = (mode_q == MODE_WORD) && (byte_s1 == ats_pkg::CH_COLON);
	assign len_end   = {1'b0, pos_q} + {{POSITION_BITS{1'b0}}, len_label};
	assign len_diff  = len_end - {1'b0, begin_q};

	always_comb begin
		if (len_end < {1'b0, begin_q})
			len_sat = '0;
		else if (len_diff[POSITION_BITS])
			len_sat = POS_MAX;
		else
			len_sat = len_diff[POSITION_BITS-1:0];
	end

	always_comb begin
		mode_n     = mode_q;
		pos_n      = pos_q;
		begin_n    = begin_q;
		line_n     = line_q;
		prefix_n   = prefix_q;
		too_long_n = too_long_q;
		go_on      = 1'b1;
		emit_a     = 1'b0;
		emit_b     = 1'b0;
		last_b_only = 1'b0;
		tok_a.kind   = ats_pkg::KIND_INT;
		tok_a.line   = ats_pkg::LINE_FIELD'(line_q);
		tok_a.start  = ats_pkg::POS_FIELD'(begin_q);
		tok_a.length = ats_pkg::POS_FIELD'(len_sat);
		tok_a.last   = 1'b0;
		tok_b.kind   = ats_pkg::KIND_ERROR;
		tok_b.line   = ats_pkg::LINE_FIELD'(line_q);
		tok_b.start  = ats_pkg::POS_FIELD'(pos_q);
		tok_b.length = ats_pkg::POS_FIELD'(1);
		tok_b.last   = 1'b1;

		case (mode_q)
			MODE_NUMBER: begin
				if (is_digit) begin
					pos_n = pos_inc;
					go_on = 1'b0;
				end else begin
					emit_a = 1'b1;
					mode_n = MODE_IDLE;
				end
			end
			MODE_WORD: begin
				if (is_word) begin
					if (prefix_q[ats_pkg::PREFIX_BITS-1 -: 8] != 8'd0)
						too_long_n = 1'b1;
					else
						prefix_n = {prefix_q[ats_pkg::PREFIX_BITS-9:0], byte_s1};
					pos_n = pos_inc;
					go_on = 1'b0;
				end else if (byte_s1 == ats_pkg::CH_COLON) begin
					emit_a      = 1'b1;
					last_b_only = 1'b1;
					tok_a.kind  = ats_pkg::KIND_LABEL;
					pos_n       = pos_inc;
					mode_n      = MODE_IDLE;
					go_on       = 1'b0;
				end else begin
					emit_a     = 1'b1;
					tok_a.kind = word_kind;
					mode_n     = MODE_IDLE;
				end
			end
			MODE_MINUS: begin
				if (is_digit) begin
					mode_n = MODE_NUMBER;
					pos_n  = pos_inc;
					go_on  = 1'b0;
				end else begin
					emit_a       = 1'b1;
					tok_a.kind   = ats_pkg::KIND_ERROR;
					tok_a.length = ats_pkg::POS_FIELD'(1);
					mode_n       = MODE_IDLE;
				end
			end
			MODE_COMMENT: begin
				if (byte_s1 != ats_pkg::CH_LF && byte_s1 != ats_pkg::CH_NUL) begin
					pos_n = pos_inc;
					go_on = 1'b0;
				end else begin
					mode_n = MODE_IDLE;
				end
			end
			default: begin
				mode_n = MODE_IDLE;
			end
		endcase

		if (go_on) begin
			if (byte_s1 == ats_pkg::CH_NUL) begin
				emit_b       = 1'b1;
				tok_b.kind   = ats_pkg::KIND_END;
				tok_b.length = '0;
				pos_n        = '0;
				begin_n      = '0;
				line_n       = LINE_BITS'(1);
				prefix_n     = '0;
				too_long_n   = 1'b0;
				mode_n       = MODE_IDLE;
			end else if (byte_s1 == ats_pkg::CH_SPACE || byte_s1 == ats_pkg::CH_TAB ||
			             byte_s1 == ats_pkg::CH_CR) begin
				pos_n = pos_inc;
			end else if (byte_s1 == ats_pkg::CH_LF) begin
				if (line_q != LINE_MAX)
					line_n = line_q + 1'b1;
				pos_n = pos_inc;
			end else if (byte_s1 == ats_pkg::CH_SEMI) begin
				mode_n = MODE_COMMENT;
				pos_n  = pos_inc;
			end else if (is_digit) begin
				begin_n = pos_q;
				mode_n  = MODE_NUMBER;
				pos_n   = pos_inc;
			end else if (byte_s1 == ats_pkg::CH_MINUS) begin
				begin_n = pos_q;
				mode_n  = MODE_MINUS;
				pos_n   = pos_inc;
			end else if (is_alpha || byte_s1 == ats_pkg::CH_UNDER) begin
				begin_n    = pos_q;
				mode_n     = MODE_WORD;
				prefix_n   = {{(ats_pkg::PREFIX_BITS-8){1'b0}}, byte_s1};
				too_long_n = 1'b0;
				pos_n      = pos_inc;
			end else begin
				emit_b = 1'b1;
				pos_n  = pos_inc;
			end
		end

		tok_a.last = !emit_b || last_b_only;
	end

	// The first pushed beat is the mode's flushed token when there is one.
	always_comb begin
		push.first  = fire && (emit_a || emit_b);
		push.second = fire && emit_a && emit_b;
		res0        = emit_a ? tok_a : tok_b;
		res1        = tok_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			pos_q      <= '0;
			begin_q    <= '0;
			line_q     <= LINE_BITS'(1);
			prefix_q   <= '0;
			too_long_q <= 1'b0;
			valid_s1   <= 1'b0;
			byte_s1    <= '0;
		end else begin
			if (fire) begin
				mode_q     <= mode_n;
				pos_q      <= pos_n;
				begin_q    <= begin_n;
				line_q     <= line_n;
				prefix_q   <= prefix_n;
				too_long_q <= too_long_n;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
				byte_s1  <= in_byte;
			end
		end
	end

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.second |-> push.first)
		else $error("second token pushed without a first");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.second |-> (!res0.last && res1.last))
		else $error("last flag misplaced on a token pair");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.first && !push.second) |-> res0.last)
		else $error("single token without last flag");

	a_no_push_unless_fire: assert property (@(posedge clk) disable iff (!arst_n)
		push.first |-> (valid_s1 && room))
		else $error("token pushed without an accepted byte");

endmodule

### rtl/core/ats_out_fifo.sv
module ats_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  ats_pkg::push_t  push,
	input  ats_pkg::token_t wr0,
	input  ats_pkg::token_t wr1,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output ats_pkg::token_t out_token
);

	localparam int DEPTH = 4;

	ats_pkg::token_t mem_q [DEPTH];
	logic [1:0]      rd_q, wr_q;
	logic [2:0]      count_q;
	logic            pop;
	logic [2:0]      n_push;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 3'd0);
	assign out_token = mem_q[rd_q];
	// Two free entries are needed since one byte can produce two beats.
	assign room      = (count_q <= 3'(DEPTH - 2));
	assign n_push    = {2'b00, push.first} + {2'b00, push.second};

	always_ff @(posedge clk) begin
		if (push.first)
			mem_q[wr_q] <= wr0;
		if (push.second)
			mem_q[wr_q + 2'd1] <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else begin
			if (pop)
				rd_q <= rd_q + 2'd1;
			wr_q    <= wr_q + n_push[1:0];
			count_q <= count_q + n_push - {2'b00, pop};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(DEPTH))
		else $error("result queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.first |-> room)
		else $error("push into a queue without room");

	a_held_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_token)))
		else $error("waiting beat changed or dropped");

endmodule
